@@ design/matrix_inverse_3x3_assert.svh @@
// Assertion macros for the 3x3 matrix inverse.
`ifndef MATRIX_INVERSE_3X3_ASSERT_SVH
`define MATRIX_INVERSE_3X3_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define MI3_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MI3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/mi3_pkg.sv @@
// Shared widths, types and the saturation function of the 3x3 matrix inverse.
package mi3_pkg;

    localparam int MAT_N  = 9;   // elements per matrix
    localparam int ELEM_W = 32;  // Q16.16 element
    localparam int COF_W  = 64;  // Q32.32 minor / cofactor
    localparam int PART_W = 65;  // element times low half of cofactor
    localparam int DET_W  = 97;  // Q49.48 determinant, signed
    localparam int MAG_W  = 96;  // determinant magnitude
    localparam int ADJ_W  = 63;  // adjugate magnitude
    localparam int QUO_W  = 32;  // quotient bits
    localparam int FRAC_W = 32;  // Q32.32 -> Q16.16 shift

    localparam logic [2*ELEM_W-1:0] NEG_LIM = 64'h0000_0000_8000_0000;
    localparam logic [2*ELEM_W-1:0] POS_LIM = 64'h0000_0000_7FFF_FFFF;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [COF_W-1:0]  cof_t;
    typedef logic signed [PART_W-1:0] part_t;
    typedef logic signed [DET_W-1:0]  det_t;
    typedef logic [MAG_W-1:0]         mag_t;
    typedef logic [ADJ_W-1:0]         adj_t;
    typedef logic [QUO_W-1:0]         quo_t;

    typedef struct packed {
        logic              singular;
        logic [ELEM_W-1:0] det_q;
    } side_t;

    // clamp a magnitude with sign to a Q16.16 pattern
    function automatic logic [ELEM_W-1:0] sat_q(input logic [2*ELEM_W-1:0] mag,
                                                input logic neg);
        logic [2*ELEM_W-1:0] lim;
        logic [ELEM_W-1:0]   v;
        lim = neg ? NEG_LIM : POS_LIM;
        v   = (mag > lim) ? lim[ELEM_W-1:0] : mag[ELEM_W-1:0];
        return neg ? (~v + 1'b1) : v;
    endfunction

endpackage

@@ design/mi3_div.sv @@
// Nine-lane pipelined restoring divider, one quotient bit per stage.
module mi3_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  mi3_pkg::side_t               in_side,
    input  mi3_pkg::adj_t                num [mi3_pkg::MAT_N],
    input  logic [mi3_pkg::MAT_N-1:0]    in_neg,
    input  mi3_pkg::mag_t                den,
    output logic                         out_valid,
    output mi3_pkg::side_t               out_side,
    output mi3_pkg::quo_t                quo [mi3_pkg::MAT_N],
    output logic [mi3_pkg::MAT_N-1:0]    ovf,
    output logic [mi3_pkg::MAT_N-1:0]    out_neg
);

    localparam int S = mi3_pkg::QUO_W;
    localparam int N = mi3_pkg::MAT_N;

    logic [S:0]          vld_reg;
    mi3_pkg::side_t      side_reg [S+1];
    mi3_pkg::mag_t       den_reg  [S+1];
    mi3_pkg::mag_t       rem_reg  [S+1][N];
    mi3_pkg::quo_t       quo_reg  [S+1][N];
    logic [N-1:0]        ovf_reg  [S+1];
    logic [N-1:0]        neg_reg  [S+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[S-1:0], in_valid};
        end
    end

    // entry: quotient would need more than 32 bits when num >= den
    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        den_reg[0]  <= den;
        neg_reg[0]  <= in_neg;
        for (int n = 0; n < N; n++)
        begin
            rem_reg[0][n] <= mi3_pkg::MAG_W'(num[n]);
            quo_reg[0][n] <= '0;
            ovf_reg[0][n] <= (mi3_pkg::MAG_W'(num[n]) >= den);
        end
    end

    for (genvar k = 0; k < S; k++)
    begin : g_step
        logic [mi3_pkg::MAG_W:0] sh       [N];
        logic [N-1:0]            ge;
        mi3_pkg::mag_t           rem_next [N];
        logic [mi3_pkg::MAG_W:0] diff     [N];

        always_comb
        begin
            for (int n = 0; n < N; n++)
            begin
                sh[n]       = {rem_reg[k][n], 1'b0};
                ge[n]       = (sh[n] >= {1'b0, den_reg[k]});
                diff[n]     = sh[n] - {1'b0, den_reg[k]};
                rem_next[n] = ge[n] ? diff[n][mi3_pkg::MAG_W-1:0]
                                    : sh[n][mi3_pkg::MAG_W-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            side_reg[k+1] <= side_reg[k];
            den_reg[k+1]  <= den_reg[k];
            ovf_reg[k+1]  <= ovf_reg[k];
            neg_reg[k+1]  <= neg_reg[k];
            for (int n = 0; n < N; n++)
            begin
                rem_reg[k+1][n] <= rem_next[n];
                quo_reg[k+1][n] <= {quo_reg[k][n][S-2:0], ge[n]};
            end
        end
    end

    assign out_valid = vld_reg[S];
    assign out_side  = side_reg[S];
    assign ovf       = ovf_reg[S];
    assign out_neg   = neg_reg[S];

    always_comb
    begin
        for (int n = 0; n < N; n++)
        begin
            quo[n] = quo_reg[S][n];
        end
    end

endmodule

@@ design/matrix_inverse_3x3.sv @@
// Top level of the 3x3 matrix inverse by adjugate, signed Q16.16.
//
// One matrix word enters on any cycle with start high; busy is always low, so
// a new word may follow every cycle. Each result word appears on r00..r22,
// det_value and singular for exactly one cycle with done high, in input
// order. The receiver cannot stall the block and nothing inside waits on it.
// The quotient is produced one bit per stage over 32 stages, ahead of which
// sit the minor products, the cofactors, the determinant partial products,
// their combine, the determinant sum and the divider entry stage, plus one
// output register (39 register stages in all). A zero determinant gives
// all-zero outputs and singular high. Quotients and the determinant
// saturate to the Q16.16 range.
module matrix_inverse_3x3 (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  mi3_pkg::elem_t       a00,
    input  mi3_pkg::elem_t       a01,
    input  mi3_pkg::elem_t       a02,
    input  mi3_pkg::elem_t       a10,
    input  mi3_pkg::elem_t       a11,
    input  mi3_pkg::elem_t       a12,
    input  mi3_pkg::elem_t       a20,
    input  mi3_pkg::elem_t       a21,
    input  mi3_pkg::elem_t       a22,
    output logic                 done,
    output mi3_pkg::elem_t       r00,
    output mi3_pkg::elem_t       r01,
    output mi3_pkg::elem_t       r02,
    output mi3_pkg::elem_t       r10,
    output mi3_pkg::elem_t       r11,
    output mi3_pkg::elem_t       r12,
    output mi3_pkg::elem_t       r20,
    output mi3_pkg::elem_t       r21,
    output mi3_pkg::elem_t       r22,
    output mi3_pkg::elem_t       det_value,
    output logic                 singular
);

    `include "matrix_inverse_3x3_assert.svh"

    localparam int N       = mi3_pkg::MAT_N;
    localparam int LATENCY = mi3_pkg::QUO_W + 7;

    mi3_pkg::elem_t am [N];

    assign am[0] = a00;
    assign am[1] = a01;
    assign am[2] = a02;
    assign am[3] = a10;
    assign am[4] = a11;
    assign am[5] = a12;
    assign am[6] = a20;
    assign am[7] = a21;
    assign am[8] = a22;

    // no internal back-pressure
    assign busy = 1'b0;

    logic            v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    mi3_pkg::cof_t   pa_reg   [N];
    mi3_pkg::cof_t   pb_reg   [N];
    mi3_pkg::elem_t  a0_1_reg [3];
    mi3_pkg::elem_t  a0_2_reg [3];
    mi3_pkg::cof_t   cof2_reg [N];
    mi3_pkg::cof_t   cof3_reg [N];
    mi3_pkg::cof_t   cof4_reg [N];
    mi3_pkg::cof_t   cof5_reg [N];
    mi3_pkg::part_t  pl_reg   [3];
    mi3_pkg::cof_t   ph_reg   [3];
    mi3_pkg::det_t   prod_reg [3];
    mi3_pkg::det_t   det_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start & ~busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // stage 1 and 2: minor products, then signed cofactors
    for (genvar i = 0; i < 3; i++)
    begin : g_row
        for (genvar j = 0; j < 3; j++)
        begin : g_col
            localparam int R0  = (i == 0) ? 1 : 0;
            localparam int R1  = (i == 2) ? 1 : 2;
            localparam int C0  = (j == 0) ? 1 : 0;
            localparam int C1  = (j == 2) ? 1 : 2;
            localparam int K   = i * 3 + j;
            localparam bit ODD = ((i + j) % 2) == 1;

            mi3_pkg::cof_t mn;
            assign mn = pa_reg[K] - pb_reg[K];

            always_ff @(posedge clk)
            begin
                pa_reg[K]   <= am[R0*3+C0] * am[R1*3+C1];
                pb_reg[K]   <= am[R0*3+C1] * am[R1*3+C0];
                cof2_reg[K] <= ODD ? -mn : mn;
            end
        end
    end

    // stage 3..5: determinant by expansion along row 0, cofactor split in halves
    for (genvar j = 0; j < 3; j++)
    begin : g_det
        always_ff @(posedge clk)
        begin
            a0_1_reg[j] <= am[j];
            a0_2_reg[j] <= a0_1_reg[j];
            pl_reg[j]   <= a0_2_reg[j] * $signed({1'b0, cof2_reg[j][mi3_pkg::FRAC_W-1:0]});
            ph_reg[j]   <= a0_2_reg[j] * $signed(cof2_reg[j][mi3_pkg::COF_W-1:mi3_pkg::FRAC_W]);
            prod_reg[j] <= (mi3_pkg::DET_W'(ph_reg[j]) <<< mi3_pkg::FRAC_W)
                         + mi3_pkg::DET_W'(pl_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
        begin
            cof3_reg[k] <= cof2_reg[k];
            cof4_reg[k] <= cof3_reg[k];
            cof5_reg[k] <= cof4_reg[k];
        end
        det_reg <= prod_reg[0] + prod_reg[1] + prod_reg[2];
    end

    // divider entry: magnitudes and signs
    mi3_pkg::det_t            det_neg;
    logic                     dneg;
    mi3_pkg::mag_t            dmag;
    mi3_pkg::side_t           side_in;
    mi3_pkg::adj_t            num [N];
    logic [N-1:0]             nneg;
    mi3_pkg::cof_t            adj [N];
    mi3_pkg::cof_t            adj_abs [N];

    always_comb
    begin
        det_neg          = -det_reg;
        dneg             = det_reg[mi3_pkg::DET_W-1];
        dmag             = dneg ? det_neg[mi3_pkg::MAG_W-1:0] : det_reg[mi3_pkg::MAG_W-1:0];
        side_in.singular = (det_reg == '0);
        side_in.det_q    = mi3_pkg::sat_q(dmag[mi3_pkg::MAG_W-1:mi3_pkg::FRAC_W], dneg);
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                // adjugate is the transposed cofactor matrix
                adj[i*3+j] = cof5_reg[j*3+i];
            end
        end
        for (int k = 0; k < N; k++)
        begin
            adj_abs[k] = adj[k][mi3_pkg::COF_W-1] ? -adj[k] : adj[k];
            num[k]     = adj_abs[k][mi3_pkg::ADJ_W-1:0];
            nneg[k]    = (adj[k][mi3_pkg::COF_W-1] != dneg) && (num[k] != '0);
        end
    end

    logic                        dv_valid;
    mi3_pkg::side_t              dv_side;
    mi3_pkg::quo_t               dv_quo [N];
    logic [N-1:0]                dv_ovf;
    logic [N-1:0]                dv_neg;

    mi3_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .in_side   (side_in),
        .num       (num),
        .in_neg    (nneg),
        .den       (dmag),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .quo       (dv_quo),
        .ovf       (dv_ovf),
        .out_neg   (dv_neg)
    );

    // output register: saturate quotients, zero everything when singular
    logic            done_reg;
    mi3_pkg::elem_t  r_reg [N];
    mi3_pkg::elem_t  detv_reg;
    logic            sing_reg;
    mi3_pkg::elem_t  r_next [N];

    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            if (dv_side.singular)
            begin
                r_next[k] = '0;
            end
            else
            begin
                r_next[k] = mi3_pkg::sat_q(dv_ovf[k] ? '1 : {{mi3_pkg::FRAC_W{1'b0}}, dv_quo[k]},
                                           dv_neg[k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
        begin
            r_reg[k] <= r_next[k];
        end
        detv_reg <= dv_side.singular ? '0 : dv_side.det_q;
        sing_reg <= dv_side.singular;
    end

    assign done      = done_reg;
    assign r00       = r_reg[0];
    assign r01       = r_reg[1];
    assign r02       = r_reg[2];
    assign r10       = r_reg[3];
    assign r11       = r_reg[4];
    assign r12       = r_reg[5];
    assign r20       = r_reg[6];
    assign r21       = r_reg[7];
    assign r22       = r_reg[8];
    assign det_value = detv_reg;
    assign singular  = sing_reg;

    // a result word only ever follows an accepted matrix word
    `MI3_ASSERT_IMPL(a_done_has_start, done, $past(start, LATENCY),
        "result word without a matching accepted matrix word")
    // singular words carry all-zero data
    `MI3_ASSERT_IMPL(a_singular_zero, done && singular,
        r00 == '0 && r11 == '0 && r22 == '0 && r01 == '0 && det_value == '0,
        "singular result with nonzero data")
    // divider output strobe turns into done in the next cycle
    `MI3_ASSERT_NEXT(a_div_to_done, dv_valid, done,
        "divider result not presented on the output")

endmodule
